// ===== hdl/llim_pkg.sv =====
// Package for the lookahead peak limiter: parameter defaults, register
// indexes and fixed field widths. No dependencies.
package llim_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int RING_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 24;

    localparam int CH_COUNT_W  = 4;
    localparam int LOOKAHEAD_W = 12;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOOKAHEAD     = 3'd4;

    localparam logic [CH_COUNT_W-1:0] CH_COUNT_RESET = 4'd2;

endpackage

// ===== hdl/lookahead_peak_limiter.sv =====
// Lookahead peak limiter top level: sequencer, registers and delay ring.
// Depends on llim_pkg, llim_ram, llim_div and llim_mac.
//
// One frame of N active channels is worked on at a time. When the peak lies
// above the threshold, the bit-serial divider works out the target gain.
// The smoothing multiply and the per-channel scaling go through one shared
// multiplier; the peak search uses its own compare path. After reset and
// after every write of the lookahead register the delay ring is swept to
// zero, one row a cycle over all RING_DEPTH rows (4096 by default);
// s_axis_tready stays low during that sweep. A finished frame waits in the
// output register while the next frame is taken in; a frame that finishes
// while that register is still held waits in its last step until the held
// beat is taken.
module lookahead_peak_limiter #(
    parameter int CHANNELS    = llim_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH  = llim_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = llim_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = llim_pkg::COEF_BITS_DEF,
    localparam int IN_W  = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = (((CHANNELS + 1) * SAMPLE_BITS + 7) / 8) * 8,
    localparam int WMAX  = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS,
    localparam int CFG_W = (WMAX > llim_pkg::LOOKAHEAD_W) ? WMAX : llim_pkg::LOOKAHEAD_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_0 .. sample_N-1, zero padding
    input  logic [IN_W-1:0]                s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_0 .. out_N-1, applied_gain, zero padding
    output logic [OUT_W-1:0]               m_axis_tdata,
    input  logic                           cfg_wr_en,
    input  logic [llim_pkg::REG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]               cfg_wr_data
);

    localparam int S  = SAMPLE_BITS;
    localparam int C  = COEF_BITS;
    localparam int MW = (S > C) ? S : C;
    localparam int PW = MW + S + 2;
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [S-1:0] UNITY = {1'b1, {(S - 1){1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PEAK = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_GMUL = 3'd3;
    localparam logic [2:0] ST_GUPD = 3'd4;
    localparam logic [2:0] ST_SMUL = 3'd5;
    localparam logic [2:0] ST_SWB  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [S-1:0]  gain_reg, gain_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [CW-1:0] nch_reg, nch_next;
    logic [CW-1:0] ch_cnt_reg, ch_cnt_next;
    logic          m_valid_reg, m_valid_next;

    logic [llim_pkg::CH_COUNT_W-1:0]  chan_count_reg;
    logic [S-1:0]                     thresh_reg;
    logic [C-1:0]                     attack_reg;
    logic [C-1:0]                     release_reg;
    logic [llim_pkg::LOOKAHEAD_W-1:0] lookahead_reg;

    logic signed [S-1:0] samp_reg [CHANNELS];
    logic [S-1:0]        res_reg [CHANNELS];
    logic [S-1:0]        peak_reg;
    logic [S-1:0]        target_reg;
    logic [OUT_W-1:0]    m_data_reg;

    logic                in_beat;
    logic                load_out;
    logic                div_start;
    logic                div_done;
    logic [S-2:0]        div_q;
    logic [IW-1:0]       ch_idx;
    logic signed [S-1:0] cur_samp;
    logic [S-1:0]        cur_u;
    logic [S-1:0]        mag;
    logic [CW-1:0]       nch_sat;
    logic [31:0]         la_wide;
    logic [AW-1:0]       la_sat;
    logic                la_zero;
    logic [AW:0]         rd_wide;
    logic [AW-1:0]       rd_addr;
    logic [C-1:0]        coef_sel;
    logic signed [S:0]   gain_diff;
    logic [MW-1:0]       mac_a;
    logic signed [S:0]   mac_b;
    logic                mac_coef_shift;
    logic signed [PW-1:0] mac_rnd;
    logic [S+1:0]        gain_sum;
    logic [S-1:0]        gain_upd;
    logic [S-1:0]        ring_rdata [CHANNELS];
    logic signed [S-1:0] scale_samp;
    logic [OUT_W-1:0]    out_word;
    logic                pick_last;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign ch_idx   = ch_cnt_reg[IW-1:0];
    assign cur_samp = samp_reg[ch_idx];
    assign cur_u    = cur_samp;
    assign mag      = cur_u[S-1] ? (~cur_u + 1'b1) : cur_u;
    assign nch_sat  = (32'(chan_count_reg) > 32'(CHANNELS)) ? CW'(CHANNELS)
                                                            : CW'(chan_count_reg);
    assign pick_last = (ch_cnt_reg == nch_reg);

    // Read address: lookahead frames behind the write position, modulo depth.
    assign la_wide = 32'(lookahead_reg);
    assign la_sat  = (la_wide > 32'(RING_DEPTH - 1)) ? AW'(RING_DEPTH - 1) : la_wide[AW-1:0];
    assign la_zero = (la_sat == '0);
    assign rd_wide = {1'b0, wr_idx_reg} + (AW + 1)'(RING_DEPTH) - {1'b0, la_sat};
    assign rd_addr = (rd_wide >= (AW + 1)'(RING_DEPTH)) ? AW'(rd_wide - (AW + 1)'(RING_DEPTH))
                                                        : rd_wide[AW-1:0];

    // Shared multiplier operands.
    assign coef_sel   = (target_reg < gain_reg) ? attack_reg : release_reg;
    assign gain_diff  = $signed({1'b0, gain_reg}) - $signed({1'b0, target_reg});
    assign scale_samp = la_zero ? samp_reg[ch_idx] : $signed(ring_rdata[ch_idx]);
    assign mac_coef_shift = (state_reg == ST_GMUL);
    assign mac_a = mac_coef_shift ? MW'(coef_sel) : MW'(gain_reg);
    assign mac_b = mac_coef_shift ? gain_diff : {scale_samp[S-1], scale_samp};
    assign gain_sum = {2'b00, target_reg} + mac_rnd[S+1:0];
    assign gain_upd = gain_sum[S-1:0];

    llim_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .aclk       (aclk),
        .op_a       (mac_a),
        .op_b       (mac_b),
        .coef_shift (mac_coef_shift),
        .rounded    (mac_rnd)
    );

    llim_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (thresh_reg),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ring
        logic          ring_we;
        logic [AW-1:0] ring_waddr;
        logic [S-1:0]  ring_wdata;

        assign ring_we    = clr_busy_reg ||
                            ((state_reg == ST_GUPD) && (CW'(ch) < nch_reg));
        assign ring_waddr = clr_busy_reg ? clr_addr_reg : wr_idx_reg;
        assign ring_wdata = clr_busy_reg ? '0 : samp_reg[ch];

        llim_ram #(
            .WIDTH (S),
            .DEPTH (RING_DEPTH)
        ) u_ring (
            .aclk  (aclk),
            .we    (ring_we),
            .waddr (ring_waddr),
            .wdata (ring_wdata),
            .raddr (rd_addr),
            .rdata (ring_rdata[ch])
        );
    end

    always_comb begin
        out_word = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            out_word[ch*S +: S] = res_reg[ch];
        end
        out_word[CHANNELS*S +: S] = gain_reg;
    end

    always_comb begin
        state_next    = state_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        gain_next     = gain_reg;
        wr_idx_next   = wr_idx_reg;
        nch_next      = nch_reg;
        ch_cnt_next   = ch_cnt_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        div_start     = 1'b0;
        load_out      = 1'b0;

        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(RING_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    nch_next    = nch_sat;
                    ch_cnt_next = '0;
                    state_next  = ST_PEAK;
                end
            end
            ST_PEAK: begin
                if (!pick_last) begin
                    ch_cnt_next = ch_cnt_reg + 1'b1;
                end else if (peak_reg > thresh_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_GMUL;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_GMUL;
                end
            end
            ST_GMUL: begin
                state_next = ST_GUPD;
            end
            ST_GUPD: begin
                gain_next   = gain_upd;
                ch_cnt_next = '0;
                state_next  = ST_SMUL;
            end
            ST_SMUL: begin
                state_next = pick_last ? ST_DONE : ST_SWB;
            end
            ST_SWB: begin
                ch_cnt_next = ch_cnt_reg + 1'b1;
                state_next  = ST_SMUL;
            end
            ST_DONE: begin
                // hold the frame until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    wr_idx_next  = (wr_idx_reg == AW'(RING_DEPTH - 1)) ? '0
                                                                      : wr_idx_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase

        if (cfg_wr_en && (cfg_wr_index == llim_pkg::REG_LOOKAHEAD)) begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
            wr_idx_next   = '0;
            gain_next     = UNITY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            gain_reg       <= UNITY;
            wr_idx_reg     <= '0;
            nch_reg        <= '0;
            ch_cnt_reg     <= '0;
            m_valid_reg    <= 1'b0;
            chan_count_reg <= llim_pkg::CH_COUNT_RESET;
            thresh_reg     <= UNITY;
            attack_reg     <= '0;
            release_reg    <= '0;
            lookahead_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            gain_reg     <= gain_next;
            wr_idx_reg   <= wr_idx_next;
            nch_reg      <= nch_next;
            ch_cnt_reg   <= ch_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    llim_pkg::REG_CHANNEL_COUNT:
                        chan_count_reg <= cfg_wr_data[llim_pkg::CH_COUNT_W-1:0];
                    llim_pkg::REG_THRESHOLD:
                        thresh_reg <= cfg_wr_data[S-1:0];
                    llim_pkg::REG_ATTACK:
                        attack_reg <= cfg_wr_data[C-1:0];
                    llim_pkg::REG_RELEASE:
                        release_reg <= cfg_wr_data[C-1:0];
                    llim_pkg::REG_LOOKAHEAD:
                        lookahead_reg <= cfg_wr_data[llim_pkg::LOOKAHEAD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                samp_reg[ch] <= s_axis_tdata[ch*S +: S];
                res_reg[ch]  <= '0;
            end
            peak_reg <= '0;
        end
        if ((state_reg == ST_PEAK) && !pick_last && (mag > peak_reg)) begin
            peak_reg <= mag;
        end
        if ((state_reg == ST_PEAK) && pick_last && !(peak_reg > thresh_reg)) begin
            target_reg <= UNITY;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            target_reg <= {1'b0, div_q};
        end
        if (state_reg == ST_SWB) begin
            res_reg[ch_idx] <= mac_rnd[S-1:0];
        end
        if (load_out) begin
            m_data_reg <= out_word;
        end
    end

endmodule

// ===== hdl/llim_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module llim_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/llim_div.sv =====
// Restoring divider, one quotient bit per cycle, for the target gain
// threshold / peak. Expects dividend < divisor. No package dependency.
module llim_div #(
    parameter int SAMPLE_BITS = 24,
    localparam int S   = SAMPLE_BITS,
    localparam int CNW = $clog2(SAMPLE_BITS)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [S-1:0] dividend,
    input  logic [S-1:0] divisor,
    output logic         done,
    output logic [S-2:0] quotient
);

    logic         active_reg, active_next;
    logic         done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [S:0]   rem_reg, rem_next;
    logic [S-2:0] quo_reg, quo_next;
    logic [S:0]   shifted;
    logic         fits;

    assign shifted = {rem_reg[S-1:0], 1'b0};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (start) begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = {1'b0, dividend};
        end else if (active_reg) begin
            rem_next = fits ? (shifted - {1'b0, divisor}) : shifted;
            quo_next = {quo_reg[S-3:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNW'(S - 2)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/llim_mac.sv =====
// Shared multiplier with registered product and round-half-up shift, used
// for the gain smoothing and for scaling each channel. No package dependency.
module llim_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24,
    localparam int S  = SAMPLE_BITS,
    localparam int C  = COEF_BITS,
    localparam int MW = (S > C) ? S : C,
    localparam int PW = MW + S + 2
) (
    input  logic                 aclk,
    input  logic [MW-1:0]        op_a,
    input  logic signed [S:0]    op_b,
    input  logic                 coef_shift,
    output logic signed [PW-1:0] rounded
);

    localparam logic signed [PW-1:0] RND_C = PW'(1) <<< (C - 1);
    localparam logic signed [PW-1:0] RND_S = PW'(1) <<< (S - 2);

    logic signed [PW-1:0] prod_reg;
    logic                 coef_shift_reg;
    logic signed [PW-1:0] sum_c, sum_s;

    always_ff @(posedge aclk) begin
        prod_reg       <= $signed({1'b0, op_a}) * op_b;
        coef_shift_reg <= coef_shift;
    end

    assign sum_c   = prod_reg + RND_C;
    assign sum_s   = prod_reg + RND_S;
    assign rounded = coef_shift_reg ? (sum_c >>> C) : (sum_s >>> (S - 1));

endmodule

// ===== hdl/llim_checker.sv =====
// Port-level checks for the lookahead peak limiter, bound to the top level.
// Depends on llim_pkg.
module llim_checker #(
    parameter int CHANNELS    = llim_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = llim_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W = (((CHANNELS + 1) * SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [OUT_W-1:0]               m_axis_tdata,
    input logic                           cfg_wr_en,
    input logic [llim_pkg::REG_IDX_W-1:0] cfg_wr_index
);

    localparam logic [SAMPLE_BITS-1:0] UNITY = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // ring sweep follows reset
    a_sweep_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_axis_tready)
        else $error("input ready while the ring sweep should be running");

    // a lookahead write restarts the sweep
    a_sweep_after_lookahead: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (cfg_wr_index == llim_pkg::REG_LOOKAHEAD) |=> !s_axis_tready)
        else $error("input ready right after a lookahead write");

    // one frame at a time
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready again in the cycle after a beat");

    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[CHANNELS*SAMPLE_BITS +: SAMPLE_BITS] <= UNITY))
        else $error("applied gain above unity");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

endmodule

bind lookahead_peak_limiter llim_checker #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_llim_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_index  (cfg_wr_index)
);

// ===== tb/sv/lookahead_peak_limiter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lookahead_peak_limiter: a cycle-free predictor of
// gain smoothing and delayed scaling, checked beat by beat. Needs llim_pkg.
module lookahead_peak_limiter_test;
    import llim_pkg::*;

    localparam int NCH  = CHANNELS_DEF;
    localparam int RING = RING_DEPTH_DEF;
    localparam int SW   = SAMPLE_BITS_DEF;
    localparam int CB   = COEF_BITS_DEF;
    localparam int CW   = (((SW > CB) ? SW : CB) > LOOKAHEAD_W) ? ((SW > CB) ? SW : CB)
                                                               : LOOKAHEAD_W;
    localparam int IN_W = NCH * SW;

    localparam int     CLK_PERIOD      = 20;
    localparam int     RESET_CYCLES    = 7;
    localparam int     WATCHDOG_CYCLES = 1_000_000;
    localparam int     SETTLE_CYCLES   = 60;
    localparam int     MAX_REPORTS     = 10;
    localparam int     QUIET_SPAN      = 24'h040000;
    localparam longint UNITY           = 64'sd1 <<< (SW - 1);

    localparam logic [SW-1:0] FULL_POS  = 24'h7FFFFF;
    localparam logic [SW-1:0] FULL_NEG  = 24'h800000;
    localparam logic [SW-1:0] MINUS_ONE = 24'hFFFFFF;
    localparam logic [SW-1:0] HALF      = 24'h400000;
    localparam logic [SW-1:0] ALT_A     = 24'hAAAAAA;
    localparam logic [SW-1:0] ALT_B     = 24'h555555;
    localparam logic [CB-1:0] COEF_MAX  = '1;

    typedef logic [NCH-1:0][SW-1:0] frame_t;
    typedef struct packed {
        logic [SW-1:0]          gain;
        logic [NCH-1:0][SW-1:0] chan;
    } limited_frame_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [$bits(limited_frame_t)-1:0] m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_wr_index  = '0;
    logic [CW-1:0]         cfg_wr_data   = '0;

    // predictor state and register shadows
    logic signed [SW-1:0]   ring_mem [NCH][RING];
    longint                 gain_lvl;
    int                     wr_pos;
    logic [CH_COUNT_W-1:0]  chan_cnt = CH_COUNT_RESET;
    logic [SW-1:0]          thresh   = FULL_NEG;
    logic [CB-1:0]          atk_coef = '0;
    logic [CB-1:0]          rel_coef = '0;
    logic [LOOKAHEAD_W-1:0] look     = '0;

    limited_frame_t pending_results[$];
    int send_idle_pct   = 24;
    int recv_idle_pct   = 67;
    int err_count       = 0;
    int frames_sent     = 0;
    int results_checked = 0;
    int frames_limited  = 0;
    int reg_writes      = 0;

    lookahead_peak_limiter u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void clear_history();
        foreach (ring_mem[ch, pos]) ring_mem[ch][pos] = '0;
        wr_pos   = 0;
        gain_lvl = UNITY;
    endfunction

    // Advance the limiter by one frame and return the beat it should emit.
    function automatic limited_frame_t apply_limiter(input frame_t f);
        int nch, rd, ch;
        longint peak, mag, target, coef, prod, held;
        limited_frame_t r;
        nch  = (chan_cnt > NCH) ? NCH : int'(chan_cnt);
        peak = 0;
        for (ch = 0; ch < nch; ch++) begin
            mag = $signed(f[ch]);
            if (mag < 0) mag = -mag;
            if (mag > peak) peak = mag;
        end
        target = UNITY;
        if (peak > longint'(thresh)) begin
            target = (longint'(thresh) <<< (SW - 1)) / peak;
            frames_limited++;
        end
        // attack when the target falls below the current gain
        coef     = (target < gain_lvl) ? longint'(atk_coef) : longint'(rel_coef);
        prod     = coef * (gain_lvl - target);
        gain_lvl = target + ((prod + (64'sd1 <<< (CB - 1))) >>> CB);

        rd = (wr_pos + RING - int'(look)) % RING;
        r  = '0;
        for (ch = 0; ch < nch; ch++) begin
            held = (look == 0) ? longint'($signed(f[ch])) : longint'(ring_mem[ch][rd]);
            prod = gain_lvl * held;
            r.chan[ch] = SW'((prod + (64'sd1 <<< (SW - 2))) >>> (SW - 1));
            ring_mem[ch][wr_pos] = f[ch];
        end
        r.gain = SW'(gain_lvl);
        wr_pos = (wr_pos + 1) % RING;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [SW-1:0] want,
                                   input logic [SW-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("result %0d: %s expected %06h, got %06h",
                     results_checked, field, want, got);
    endtask

    always @(posedge aclk) begin
        limited_frame_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("result %0d: beat with nothing outstanding, data %h",
                             results_checked, got);
            end else begin
                want = pending_results.pop_front();
                for (int ch = 0; ch < NCH; ch++)
                    if (got.chan[ch] !== want.chan[ch])
                        report_mismatch($sformatf("out_%0d", ch), want.chan[ch], got.chan[ch]);
                if (got.gain !== want.gain)
                    report_mismatch("applied_gain", want.gain, got.gain);
            end
            results_checked++;
        end
    end

    // Entered and left just after a falling edge; tvalid is left high.
    task automatic send_frame(input frame_t f);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(apply_limiter(f));
        frames_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CHANNEL_COUNT: chan_cnt = value[CH_COUNT_W-1:0];
            REG_THRESHOLD:     thresh   = value[SW-1:0];
            REG_ATTACK:        atk_coef = value[CB-1:0];
            REG_RELEASE:       rel_coef = value[CB-1:0];
            REG_LOOKAHEAD: begin
                look = value[LOOKAHEAD_W-1:0];
                clear_history();
            end
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_frame({NCH{FULL_POS}});
        send_frame({NCH{FULL_NEG}});
        send_frame('0);
        send_frame({NCH/2{ALT_A, ALT_B}});
        send_frame({NCH{MINUS_ONE}});
    endtask

    task automatic test_limiting_cases();
        frame_t f;
        wait_for_results();
        write_reg(REG_CHANNEL_COUNT, CW'(NCH));
        write_reg(REG_THRESHOLD, HALF);
        write_reg(REG_ATTACK, '0);
        write_reg(REG_RELEASE, 24'hC00000);
        write_reg(REG_LOOKAHEAD, CW'(1));
        send_frame({NCH{FULL_POS}});
        send_frame({NCH{HALF}});          // peak equal to threshold: no limiting
        f = '0;
        f[NCH-1] = FULL_NEG;              // full-scale negative on the last lane
        send_frame(f);
        send_frame({NCH{24'h000100}});
        send_frame({NCH{24'h000100}});
        send_frame({NCH{24'hC00000}});
    endtask

    task automatic test_register_edges();
        wait_for_results();
        write_reg(REG_THRESHOLD, '0);
        send_frame({NCH{24'h000001}});    // any signal drives the gain to zero
        send_frame('0);
        wait_for_results();
        write_reg(REG_THRESHOLD, MINUS_ONE);
        send_frame({NCH{FULL_NEG}});
        wait_for_results();
        write_reg(REG_THRESHOLD, HALF);
        write_reg(REG_ATTACK, COEF_MAX);
        write_reg(REG_RELEASE, '0);
        send_frame({NCH{FULL_POS}});
        send_frame('0);
        wait_for_results();
        write_reg(REG_CHANNEL_COUNT, '0);
        send_frame({NCH{FULL_POS}});
        wait_for_results();
        write_reg(REG_CHANNEL_COUNT, '1);
        send_frame({NCH{FULL_NEG}});
        wait_for_results();
        write_reg(REG_CHANNEL_COUNT, CW'(1));
        send_frame({NCH{ALT_A}});
        wait_for_results();
        for (int idx = int'(REG_LOOKAHEAD) + 1; idx < (1 << REG_IDX_W); idx++)
            write_reg(REG_IDX_W'(idx), CW'($urandom()));
        send_frame({NCH{ALT_B}});
        wait_for_results();
        write_reg(REG_LOOKAHEAD, CW'(look));  // same value still clears the history
        send_frame({NCH{ALT_B}});
        wait_for_results();
        write_reg(REG_LOOKAHEAD, CW'(RING - 1));
        send_frame({NCH{FULL_POS}});
        send_frame({NCH{FULL_NEG}});
    endtask

    task automatic test_random_traffic(input int n_frames, input int send_pct,
                                       input int recv_pct);
        frame_t f;
        int pick, lane;
        wait_for_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_frames; i++) begin
            if (i % 50 == 0) begin
                wait_for_results();
                pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, NCH);
                write_reg(REG_CHANNEL_COUNT, CW'(pick));
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_THRESHOLD, '0);
                    1:       write_reg(REG_THRESHOLD, FULL_NEG);
                    2:       write_reg(REG_THRESHOLD, MINUS_ONE);
                    default: write_reg(REG_THRESHOLD, CW'($urandom_range(24'h080000, FULL_POS)));
                endcase
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_ATTACK, '0);
                    1:       write_reg(REG_ATTACK, COEF_MAX);
                    default: write_reg(REG_ATTACK, CW'($urandom()));
                endcase
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_RELEASE, '0);
                    1:       write_reg(REG_RELEASE, COEF_MAX);
                    default: write_reg(REG_RELEASE, CW'($urandom()));
                endcase
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_LOOKAHEAD, '0);
                    1:       write_reg(REG_LOOKAHEAD, CW'(RING - 1));
                    2:       write_reg(REG_LOOKAHEAD, CW'($urandom_range(0, RING - 1)));
                    default: write_reg(REG_LOOKAHEAD, CW'($urandom_range(1, 8)));
                endcase
            end else if (i % 37 == 18) begin
                wait_for_results();       // hold off until the pipe is empty
            end

            // mix of raw noise, quiet passages, loud bursts and full-scale values
            pick = $urandom_range(0, 9);
            for (int ch = 0; ch < NCH; ch++) begin
                if (pick < 4)
                    f[ch] = SW'($urandom());
                else if (pick < 9)
                    f[ch] = SW'($urandom_range(0, 2 * QUIET_SPAN) - QUIET_SPAN);
                else
                    case ($urandom_range(0, 3))
                        0:       f[ch] = FULL_POS;
                        1:       f[ch] = FULL_NEG;
                        2:       f[ch] = MINUS_ONE;
                        default: f[ch] = '0;
                    endcase
            end
            if (pick == 7 || pick == 8) begin
                lane = $urandom_range(0, NCH - 1);
                f[lane] = $urandom_range(0, 1) ? FULL_POS - SW'($urandom_range(0, 24'h1FFFFF))
                                               : FULL_NEG + SW'($urandom_range(0, 24'h1FFFFF));
            end
            send_frame(f);
        end
    endtask

    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge aclk);
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        clear_history();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_limiting_cases();
        test_register_edges();
        test_random_traffic(200, 24, 67);
        test_random_traffic(200, 67, 24);
        test_random_traffic(200, 0, 0);
        wait_for_results();

        $display("%0d frames sent, %0d beats compared, %0d frames above threshold",
                 frames_sent, results_checked, frames_limited);
        $display("%0d register writes across directed and random settings, %0d mismatches",
                 reg_writes, err_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/llim_pkg.sv
hdl/llim_ram.sv
hdl/llim_div.sv
hdl/llim_mac.sv
hdl/lookahead_peak_limiter.sv
hdl/llim_checker.sv
tb/sv/lookahead_peak_limiter_test.sv
